### rtl/ectd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ectd_pkg
// Shared operation codes and the status bundle between the controller and the
// datapath of the epoch to calendar date converter.
// ----------------------------------------------------------------------------
package ectd_pkg;

    localparam int OP_W = 4;
    typedef logic [OP_W-1:0] t_op;

    localparam t_op OP_NOP     = 4'd0;
    localparam t_op OP_LOAD    = 4'd1;  // capture uptime
    localparam t_op OP_DIV_DIF = 4'd2;  // start (uptime - base) / 1000
    localparam t_op OP_DIV_UP  = 4'd3;  // start uptime / 1000
    localparam t_op OP_DIV_DAY = 4'd4;  // start epoch / 86400
    localparam t_op OP_STEP    = 4'd5;  // one divider step
    localparam t_op OP_USEC    = 4'd6;  // start uptime seconds / 3600
    localparam t_op OP_DAY     = 4'd7;  // keep days, start sod / 3600
    localparam t_op OP_HOUR    = 4'd8;  // keep hour and start / 60, or start hours / 100
    localparam t_op OP_HMOD    = 4'd9;  // keep hours mod 100, start / 60
    localparam t_op OP_MINSEC  = 4'd10; // keep minute and second
    localparam t_op OP_YEAR    = 4'd11; // subtract one year
    localparam t_op OP_MON     = 4'd12; // subtract one month
    localparam t_op OP_OUT     = 4'd13; // register result

    typedef struct packed {
        logic eb_zero;
        logic sum_zero;
        logic div_last;
        logic known;
        logic year_done;
        logic mon_done;
    } t_stat;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_EPOCH_BASE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPTIME_BASE = 8'd1;

endpackage
`default_nettype wire

### rtl/ectd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ectd_ctrl
// Sequencer: walks the divisions, the year count and the month count, and
// issues one datapath operation per cycle.
// ----------------------------------------------------------------------------
module ectd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire ectd_pkg::t_stat i_stat,
    output ectd_pkg::t_op      o_op,
    output logic               o_busy
);
    import ectd_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHK    = 4'd1;
    localparam logic [3:0] S_DIVD   = 4'd2;
    localparam logic [3:0] S_SUM    = 4'd3;
    localparam logic [3:0] S_DIVU   = 4'd4;
    localparam logic [3:0] S_USEC   = 4'd5;
    localparam logic [3:0] S_DIVDAY = 4'd6;
    localparam logic [3:0] S_DAY    = 4'd7;
    localparam logic [3:0] S_DIVH   = 4'd8;
    localparam logic [3:0] S_HOUR   = 4'd9;
    localparam logic [3:0] S_DIVC   = 4'd10;
    localparam logic [3:0] S_HMOD   = 4'd11;
    localparam logic [3:0] S_DIVM   = 4'd12;
    localparam logic [3:0] S_MS     = 4'd13;
    localparam logic [3:0] S_YEAR   = 4'd14;
    localparam logic [3:0] S_MON    = 4'd15;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_op    = OP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_op    = OP_LOAD;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (i_stat.eb_zero) begin
                    o_op    = OP_DIV_UP;
                    n_state = S_DIVU;
                end else begin
                    o_op    = OP_DIV_DIF;
                    n_state = S_DIVD;
                end
            end
            S_DIVD: begin
                o_op = OP_STEP;
                if (i_stat.div_last) n_state = S_SUM;
            end
            S_SUM: begin
                if (i_stat.sum_zero) begin
                    o_op    = OP_DIV_UP;
                    n_state = S_DIVU;
                end else begin
                    o_op    = OP_DIV_DAY;
                    n_state = S_DIVDAY;
                end
            end
            S_DIVU: begin
                o_op = OP_STEP;
                if (i_stat.div_last) n_state = S_USEC;
            end
            S_USEC: begin
                o_op    = OP_USEC;
                n_state = S_DIVH;
            end
            S_DIVDAY: begin
                o_op = OP_STEP;
                if (i_stat.div_last) n_state = S_DAY;
            end
            S_DAY: begin
                o_op    = OP_DAY;
                n_state = S_DIVH;
            end
            S_DIVH: begin
                o_op = OP_STEP;
                if (i_stat.div_last) n_state = S_HOUR;
            end
            S_HOUR: begin
                o_op    = OP_HOUR;
                n_state = i_stat.known ? S_DIVM : S_DIVC;
            end
            S_DIVC: begin
                o_op = OP_STEP;
                if (i_stat.div_last) n_state = S_HMOD;
            end
            S_HMOD: begin
                o_op    = OP_HMOD;
                n_state = S_DIVM;
            end
            S_DIVM: begin
                o_op = OP_STEP;
                if (i_stat.div_last) n_state = S_MS;
            end
            S_MS: begin
                o_op    = OP_MINSEC;
                n_state = i_stat.known ? S_YEAR : S_MON;
            end
            S_YEAR: begin
                if (i_stat.year_done) begin
                    n_state = S_MON;
                end else begin
                    o_op = OP_YEAR;
                end
            end
            S_MON: begin
                // unknown date comes straight here; month count is skipped
                if (i_stat.mon_done || !i_stat.known) begin
                    o_op    = OP_OUT;
                    n_state = S_IDLE;
                end else begin
                    o_op = OP_MON;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

### rtl/ectd_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ectd_dp
// Datapath: shared reciprocal-multiply divider for constant divisors, year and
// month subtraction counters, and the result registers.
// ----------------------------------------------------------------------------
module ectd_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ectd_pkg::t_op i_op,
    input  wire logic [31:0]   i_uptime_ms,
    input  wire logic [31:0]   i_epoch_base,
    input  wire logic [31:0]   i_uptime_base,
    output ectd_pkg::t_stat    o_stat,
    output logic               o_valid,
    output logic               o_date_known,
    output logic [11:0]        o_year,
    output logic [3:0]         o_month,
    output logic [4:0]         o_day,
    output logic [6:0]         o_hour,
    output logic [5:0]         o_minute,
    output logic [5:0]         o_second
);
    import ectd_pkg::*;

    localparam logic [16:0] D_MS   = 17'd1000;
    localparam logic [16:0] D_DAY  = 17'd86400;
    localparam logic [16:0] D_HOUR = 17'd3600;
    localparam logic [16:0] D_MIN  = 17'd60;
    localparam logic [16:0] D_HMOD = 17'd100;
    // reciprocals ceil(2^s / d), exact for any 32-bit dividend
    localparam logic [31:0] M_MS   = 32'h1062_4DD3;  // s = 38
    localparam logic [31:0] M_DAY  = 32'hC22E_4507;  // s = 48
    localparam logic [31:0] M_HOUR = 32'h91A2_B3C5;  // s = 43
    localparam logic [31:0] M_MIN  = 32'h8888_8889;  // s = 37
    localparam logic [31:0] M_HMOD = 32'h51EB_851F;  // s = 37
    localparam logic [11:0] FIRST_YEAR = 12'd1970;
    localparam logic [1:0]  Y4_INIT    = 2'd2;
    localparam logic [6:0]  Y100_INIT  = 7'd70;
    localparam logic [8:0]  Y400_INIT  = 9'd370;

    logic [31:0] r_up;
    logic [31:0] r_dq;
    logic [16:0] r_rem;
    logic [16:0] r_div;
    logic        r_ph;
    logic [63:0] r_prod;
    logic [11:0] r_rest;
    logic [15:0] r_days;
    logic [11:0] r_year;
    logic [1:0]  r_y4;
    logic [6:0]  r_y100;
    logic [8:0]  r_y400;
    logic [3:0]  r_mon;
    logic        r_known;
    logic [6:0]  r_hr;
    logic [5:0]  r_min;
    logic [5:0]  r_sec;

    logic [31:0] w_magic;
    logic [31:0] w_quo;
    logic [33:0] w_qd;
    logic [16:0] w_rem;
    logic [31:0] w_sum;
    logic        w_leap;
    logic [8:0]  w_ylen;
    logic [4:0]  w_mlen;

    always_comb begin
        unique case (r_div)
            D_MS: begin
                w_magic = M_MS;
                w_quo   = {6'd0, r_prod[63:38]};
            end
            D_DAY: begin
                w_magic = M_DAY;
                w_quo   = {16'd0, r_prod[63:48]};
            end
            D_HOUR: begin
                w_magic = M_HOUR;
                w_quo   = {11'd0, r_prod[63:43]};
            end
            D_MIN: begin
                w_magic = M_MIN;
                w_quo   = {5'd0, r_prod[63:37]};
            end
            default: begin
                w_magic = M_HMOD;
                w_quo   = {5'd0, r_prod[63:37]};
            end
        endcase
    end

    assign w_qd    = {17'd0, w_quo[16:0]} * {17'd0, r_div};
    assign w_rem   = r_dq[16:0] - w_qd[16:0];
    assign w_sum   = i_epoch_base + r_dq;
    assign w_leap  = ((r_y4 == 2'd0) && (r_y100 != 7'd0)) || (r_y400 == 9'd0);
    assign w_ylen  = w_leap ? 9'd366 : 9'd365;

    always_comb begin
        unique case (r_mon)
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: w_mlen = 5'd31;
            4'd1:    w_mlen = w_leap ? 5'd29 : 5'd28;
            default: w_mlen = 5'd30;
        endcase
    end

    always_comb begin
        o_stat.eb_zero   = (i_epoch_base == 32'd0);
        o_stat.sum_zero  = (w_sum == 32'd0);
        o_stat.div_last  = r_ph;
        o_stat.known     = r_known;
        o_stat.year_done = (r_days < {7'd0, w_ylen});
        o_stat.mon_done  = (r_days < {11'd0, w_mlen});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= (i_op == OP_OUT);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_LOAD: begin
                r_up    <= i_uptime_ms;
                r_known <= 1'b0;
            end
            OP_DIV_DIF: begin
                r_dq  <= r_up - i_uptime_base;
                r_rem <= '0;
                r_div <= D_MS;
                r_ph  <= 1'b0;
            end
            OP_DIV_UP: begin
                r_dq  <= r_up;
                r_rem <= '0;
                r_div <= D_MS;
                r_ph  <= 1'b0;
            end
            OP_DIV_DAY: begin
                r_dq  <= w_sum;
                r_rem <= '0;
                r_div <= D_DAY;
                r_ph  <= 1'b0;
            end
            OP_STEP: begin
                if (!r_ph) begin
                    r_prod <= {32'd0, r_dq} * {32'd0, w_magic};
                end else begin
                    r_dq  <= w_quo;
                    r_rem <= w_rem;
                end
                r_ph <= ~r_ph;
            end
            OP_USEC: begin
                r_rem <= '0;
                r_div <= D_HOUR;
                r_ph  <= 1'b0;
            end
            OP_DAY: begin
                r_days  <= r_dq[15:0];
                r_dq    <= {15'd0, r_rem};
                r_rem   <= '0;
                r_div   <= D_HOUR;
                r_ph    <= 1'b0;
                r_known <= 1'b1;
                r_year  <= FIRST_YEAR;
                r_y4    <= Y4_INIT;
                r_y100  <= Y100_INIT;
                r_y400  <= Y400_INIT;
                r_mon   <= '0;
            end
            OP_HOUR: begin
                if (r_known) begin
                    r_hr <= r_dq[6:0];
                    r_dq <= {20'd0, r_rem[11:0]};
                    r_div <= D_MIN;
                end else begin
                    r_rest <= r_rem[11:0];
                    r_div  <= D_HMOD;
                end
                r_rem <= '0;
                r_ph  <= 1'b0;
            end
            OP_HMOD: begin
                r_hr  <= r_rem[6:0];
                r_dq  <= {20'd0, r_rest};
                r_rem <= '0;
                r_div <= D_MIN;
                r_ph  <= 1'b0;
            end
            OP_MINSEC: begin
                r_min <= r_dq[5:0];
                r_sec <= r_rem[5:0];
            end
            OP_YEAR: begin
                r_days <= r_days - {7'd0, w_ylen};
                r_year <= r_year + 12'd1;
                r_y4   <= r_y4 + 2'd1;
                r_y100 <= (r_y100 == 7'd99) ? 7'd0 : r_y100 + 7'd1;
                r_y400 <= (r_y400 == 9'd399) ? 9'd0 : r_y400 + 9'd1;
            end
            OP_MON: begin
                r_days <= r_days - {11'd0, w_mlen};
                r_mon  <= r_mon + 4'd1;
            end
            OP_OUT: begin
                o_date_known <= r_known;
                o_year       <= r_known ? r_year : 12'd0;
                o_month      <= r_known ? r_mon + 4'd1 : 4'd0;
                o_day        <= r_known ? r_days[4:0] + 5'd1 : 5'd0;
                o_hour       <= r_hr;
                o_minute     <= r_min;
                o_second     <= r_sec;
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/epoch_to_calendar_date.sv
`default_nettype none
// ----------------------------------------------------------------------------
// epoch_to_calendar_date
// Millisecond uptime to Gregorian date and time of day, from a configured
// Unix epoch base and the uptime captured with it.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: i_start with i_uptime_ms, taken when o_busy is low.
//   Result channel: o_valid strobes for one cycle with all date fields; the
//   receiver cannot stall, so each result must be taken as it appears.
//   Config channel: i_cfg_valid/o_cfg_ready with i_cfg_index and
//   i_cfg_wdata; index 0 epoch base, 1 uptime base, others ignored.
//   Write config only while o_busy is low and no result is pending.
// Sequence: with no epoch base, or when the sum wraps to zero, only the
//   time of day is found from the uptime. A known date also runs the year
//   and month counts, one year or month subtracted per step from 1970.
//   Divisions are reciprocal multiplies. One request is in flight at a
//   time, and the next is taken while the strobe is high.
// Reset: synchronous, active low; both bases clear to zero (date unknown)
//   and the sequencer returns to idle.
// ----------------------------------------------------------------------------
module epoch_to_calendar_date (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    output logic                               o_busy,
    input  wire logic [31:0]                   i_uptime_ms,
    output logic                               o_valid,
    output logic                               o_date_known,
    output logic [11:0]                        o_year,
    output logic [3:0]                         o_month,
    output logic [4:0]                         o_day,
    output logic [6:0]                         o_hour,
    output logic [5:0]                         o_minute,
    output logic [5:0]                         o_second,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [ectd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                   i_cfg_wdata
);
    import ectd_pkg::*;

    logic [31:0] r_epoch_base;
    logic [31:0] r_uptime_base;
    t_op         w_op;
    t_stat       w_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch_base  <= '0;
            r_uptime_base <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_EPOCH_BASE) r_epoch_base <= i_cfg_wdata;
            if (i_cfg_index == REG_UPTIME_BASE) r_uptime_base <= i_cfg_wdata;
        end
    end

    ectd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (w_stat),
        .o_op    (w_op),
        .o_busy  (o_busy)
    );

    ectd_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (w_op),
        .i_uptime_ms   (i_uptime_ms),
        .i_epoch_base  (r_epoch_base),
        .i_uptime_base (r_uptime_base),
        .o_stat        (w_stat),
        .o_valid       (o_valid),
        .o_date_known  (o_date_known),
        .o_year        (o_year),
        .o_month       (o_month),
        .o_day         (o_day),
        .o_hour        (o_hour),
        .o_minute      (o_minute),
        .o_second      (o_second)
    );

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("request accepted but sequencer not busy");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result strobe while sequencer busy");

    a_unknown_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_date_known) |-> (o_year == 12'd0 && o_month == 4'd0 && o_day == 5'd0))
        else $error("unknown date with non-zero date fields");

    a_known_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_date_known) |->
            (o_hour < 7'd24 && o_month >= 4'd1 && o_month <= 4'd12 && o_day != 5'd0))
        else $error("known date out of range");
`endif

endmodule
`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb - epoch_to_calendar_date testbench
// Drives uptime requests against a range of epoch and uptime base settings and
// compares every strobed timestamp, field by field, with a local calendar
// model. A directed table covers reset state, field extremes, register wrap,
// ignored register indexes and leap boundaries. Random traffic under three
// sender idling profiles follows.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ectd_pkg::*;

    typedef struct packed {
        logic        known;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [6:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_date;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic                   pin;
        logic [CFG_IDX_W-1:0]   idx;
        logic [31:0]            data;
        t_date                  res;
    } t_dir_row;

    typedef enum int {SET_UNSET, SET_WRAP, SET_HOT, SET_SPREAD} t_setting;

    localparam logic [CFG_IDX_W-1:0] REG_STRAY_LO = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRAY_HI = 8'd255;

    localparam t_date NO_DATE = '0;
    localparam t_date TOP_DATE = '{1'b1, 12'd2106, 4'd2, 5'd7, 7'd6, 6'd28, 6'd15};
    localparam t_date FIRST_SEC = '{1'b1, 12'd1970, 4'd1, 5'd1, 7'd0, 6'd0, 6'd1};

    localparam int NUM_DIR = 31;
    localparam t_dir_row DIRECTED_ROWS [NUM_DIR] = '{
        '{ROW_REQ, 1'b1, 8'd0, 32'h0000_0000, NO_DATE},
        '{ROW_REQ, 1'b1, 8'd0, 32'hFFFF_FFFF,
          '{1'b0, 12'd0, 4'd0, 5'd0, 7'd93, 6'd2, 6'd47}},
        '{ROW_CFG, 1'b0, REG_EPOCH_BASE, 32'd1, NO_DATE},
        '{ROW_REQ, 1'b1, 8'd0, 32'd0, FIRST_SEC},
        '{ROW_REQ, 1'b0, 8'd0, 32'd86_400_000, NO_DATE},
        '{ROW_CFG, 1'b0, REG_EPOCH_BASE, 32'hFFFF_FFFF, NO_DATE},
        '{ROW_REQ, 1'b1, 8'd0, 32'd999, TOP_DATE},
        '{ROW_REQ, 1'b1, 8'd0, 32'd1000,
          '{1'b0, 12'd0, 4'd0, 5'd0, 7'd0, 6'd0, 6'd1}},
        '{ROW_CFG, 1'b0, REG_UPTIME_BASE, 32'hFFFF_FFFF, NO_DATE},
        '{ROW_REQ, 1'b1, 8'd0, 32'hFFFF_FFFF, TOP_DATE},
        '{ROW_REQ, 1'b0, 8'd0, 32'd0, NO_DATE},
        '{ROW_REQ, 1'b0, 8'd0, 32'd999, NO_DATE},
        '{ROW_CFG, 1'b0, REG_UPTIME_BASE, 32'd1000, NO_DATE},
        '{ROW_CFG, 1'b0, REG_EPOCH_BASE, 32'd1, NO_DATE},
        '{ROW_REQ, 1'b0, 8'd0, 32'd0, NO_DATE},
        '{ROW_CFG, 1'b0, REG_STRAY_LO, 32'hFFFF_FFFF, NO_DATE},
        '{ROW_CFG, 1'b0, REG_STRAY_HI, 32'h0000_0000, NO_DATE},
        '{ROW_REQ, 1'b1, 8'd0, 32'd1999, FIRST_SEC},
        '{ROW_CFG, 1'b0, REG_UPTIME_BASE, 32'd0, NO_DATE},
        '{ROW_CFG, 1'b0, REG_EPOCH_BASE, 32'd951_782_400, NO_DATE},
        '{ROW_REQ, 1'b0, 8'd0, 32'd0, NO_DATE},
        '{ROW_REQ, 1'b0, 8'd0, 32'd86_399_999, NO_DATE},
        '{ROW_CFG, 1'b0, REG_EPOCH_BASE, 32'd4_107_542_399, NO_DATE},
        '{ROW_REQ, 1'b0, 8'd0, 32'd0, NO_DATE},
        '{ROW_REQ, 1'b0, 8'd0, 32'd1000, NO_DATE},
        '{ROW_CFG, 1'b0, REG_EPOCH_BASE, 32'd94_694_399, NO_DATE},
        '{ROW_REQ, 1'b0, 8'd0, 32'd0, NO_DATE},
        '{ROW_REQ, 1'b0, 8'd0, 32'd1000, NO_DATE},
        '{ROW_CFG, 1'b0, REG_EPOCH_BASE, 32'd0, NO_DATE},
        '{ROW_REQ, 1'b0, 8'd0, 32'h8000_0000, NO_DATE},
        '{ROW_REQ, 1'b0, 8'd0, 32'h7FFF_FFFF, NO_DATE}
    };

    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int IDLE_PCT [3] = '{29, 69, 0};
    localparam int ITEMS_PER_PHASE = 430;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES = 400;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_start = 1'b0;
    logic [31:0]          i_uptime_ms = '0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_wdata = '0;
    logic                 o_busy;
    logic                 o_valid;
    logic                 o_date_known;
    logic [11:0]          o_year;
    logic [3:0]           o_month;
    logic [4:0]           o_day;
    logic [6:0]           o_hour;
    logic [5:0]           o_minute;
    logic [5:0]           o_second;
    logic                 o_cfg_ready;

    // expectation pinned to the next request, moved alongside the inputs
    logic  pin_valid = 1'b0;
    t_date pin_res = '0;

    logic [31:0] epoch_base_q = '0;
    logic [31:0] uptime_base_q = '0;
    t_date       dates_due [$];
    int          requests_issued = 0;
    int          results_seen = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;

    epoch_to_calendar_date uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_uptime_ms  (i_uptime_ms),
        .o_valid      (o_valid),
        .o_date_known (o_date_known),
        .o_year       (o_year),
        .o_month      (o_month),
        .o_day        (o_day),
        .o_hour       (o_hour),
        .o_minute     (o_minute),
        .o_second     (o_second),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    function automatic bit is_leap(input int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
    endfunction

    function automatic int unsigned days_to_year(input int unsigned y);
        int unsigned n;
        n = 0;
        for (int unsigned k = 1970; k < y; k++) n += is_leap(k) ? 366 : 365;
        return n;
    endfunction

    function automatic t_date predict_date(input logic [31:0] now_ms, eb, ub);
        logic [31:0] unix_s;
        logic [31:0] up_s;
        logic [31:0] days;
        logic [31:0] sod;
        logic [31:0] mlen;
        int unsigned yr;
        int unsigned mon;
        t_date d;
        d = '0;
        unix_s = '0;
        if (eb != 32'd0) unix_s = eb + (now_ms - ub) / 32'd1000;
        if (unix_s == 32'd0) begin
            up_s = now_ms / 32'd1000;
            d.hour = 7'((up_s / 32'd3600) % 32'd100);
            d.minute = 6'((up_s % 32'd3600) / 32'd60);
            d.second = 6'(up_s % 32'd60);
            return d;
        end
        days = unix_s / 32'd86400;
        sod = unix_s % 32'd86400;
        yr = 1970;
        while (days >= (is_leap(yr) ? 32'd366 : 32'd365)) begin
            days -= is_leap(yr) ? 32'd366 : 32'd365;
            yr++;
        end
        mon = 0;
        while (mon < 12) begin
            mlen = MONTH_DAYS[mon];
            if (mon == 1 && is_leap(yr)) mlen = 32'd29;
            if (days < mlen) break;
            days -= mlen;
            mon++;
        end
        d.known = 1'b1;
        d.year = 12'(yr);
        d.month = 4'(mon + 1);
        d.day = 5'(days + 1);
        d.hour = 7'(sod / 32'd3600);
        d.minute = 6'((sod % 32'd3600) / 32'd60);
        d.second = 6'(sod % 32'd60);
        return d;
    endfunction

    function automatic logic [31:0] pick_uptime(input t_setting kind, input logic [31:0] eb, ub);
        case (kind)
            SET_WRAP:   return ub + (32'd0 - eb) * 32'd1000 + $urandom_range(0, 4000) - 32'd2000;
            SET_HOT:    return ub + $urandom_range(0, 300_000);
            SET_SPREAD: return $urandom_range(0, 1) ? $urandom : ub + $urandom_range(0, 32'h1000_0000);
            default:    return $urandom;
        endcase
    endfunction

    task automatic check_field(input string fname, input int unsigned want, input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
        end
    endtask

    task automatic send_request(input logic [31:0] up, input logic pin, input t_date res);
        i_start <= 1'b1;
        i_uptime_ms <= up;
        i_cfg_valid <= 1'b0;
        pin_valid <= pin;
        pin_res <= res;
        do @(posedge i_clk); while (o_busy);
        requests_issued++;
    endtask

    task automatic idle_gap(input int pct);
        while ($urandom_range(0, 99) < pct) begin
            i_start <= 1'b0;
            i_uptime_ms <= $urandom;
            @(posedge i_clk);
        end
        if (pct != 0 && $urandom_range(0, 31) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 300)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (results_seen != requests_issued || o_busy) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic apply_setting(output t_setting kind, output logic [31:0] eb, ub);
        int unsigned roll;
        int unsigned yr;
        int unsigned day_no;
        roll = $urandom_range(0, 9);
        kind = roll == 0 ? SET_UNSET : roll == 1 ? SET_WRAP : roll <= 4 ? SET_HOT : SET_SPREAD;
        case ($urandom_range(0, 7))
            0:       ub = '0;
            1:       ub = '1;
            default: ub = $urandom;
        endcase
        case (kind)
            SET_UNSET: eb = '0;
            SET_WRAP:  eb = 32'd0 - $urandom_range(1, 4000);
            SET_HOT: begin
                // land just before midnight on the first and last day of a year and around leap days
                yr = $urandom_range(1970, 2105);
                day_no = days_to_year(yr);
                case ($urandom_range(0, 4))
                    1:       day_no += 58;
                    2:       day_no += 59;
                    3:       day_no += 60;
                    4:       day_no += is_leap(yr) ? 365 : 364;
                    default: ;
                endcase
                eb = day_no * 32'd86400 + 32'd86400 - $urandom_range(1, 120);
            end
            default:   eb = $urandom;
        endcase
        drain();
        if ($urandom_range(0, 3) == 0) write_reg(CFG_IDX_W'($urandom_range(2, 255)), $urandom);
        if ($urandom_range(0, 1)) begin
            write_reg(REG_EPOCH_BASE, eb);
            write_reg(REG_UPTIME_BASE, ub);
        end else begin
            write_reg(REG_UPTIME_BASE, ub);
            write_reg(REG_EPOCH_BASE, eb);
        end
    endtask

    always @(posedge i_clk) begin
        t_date want;
        bit    moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                case (i_cfg_index)
                    REG_EPOCH_BASE:  epoch_base_q = i_cfg_wdata;
                    REG_UPTIME_BASE: uptime_base_q = i_cfg_wdata;
                    default:         ;
                endcase
            end
            if (i_start && !o_busy) begin
                moved = 1'b1;
                dates_due.push_back(pin_valid ? pin_res
                                    : predict_date(i_uptime_ms, epoch_base_q, uptime_base_q));
            end
            if (o_valid) begin
                moved = 1'b1;
                results_seen++;
                if (dates_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with no request pending, actual %0d-%0d-%0d %0d:%0d:%0d",
                             $time, o_year, o_month, o_day, o_hour, o_minute, o_second);
                end else begin
                    want = dates_due.pop_front();
                    check_field("date_known", want.known, o_date_known);
                    check_field("year", want.year, o_year);
                    check_field("month", want.month, o_month);
                    check_field("day", want.day, o_day);
                    check_field("hour", want.hour, o_hour);
                    check_field("minute", want.minute, o_minute);
                    check_field("second", want.second, o_second);
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("epoch_to_calendar_date verification failed");
                $finish;
            end
        end
    end

    initial begin
        t_setting    kind;
        logic [31:0] eb;
        logic [31:0] ub;
        int          sent_in_phase;
        int          seg;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < NUM_DIR; r++) begin
            if (DIRECTED_ROWS[r].kind == ROW_CFG) begin
                drain();
                write_reg(DIRECTED_ROWS[r].idx, DIRECTED_ROWS[r].data);
            end else begin
                send_request(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].pin, DIRECTED_ROWS[r].res);
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            sent_in_phase = 0;
            while (sent_in_phase < ITEMS_PER_PHASE) begin
                apply_setting(kind, eb, ub);
                seg = $urandom_range(10, 60);
                repeat (seg) begin
                    send_request(pick_uptime(kind, eb, ub), 1'b0, NO_DATE);
                    idle_gap(IDLE_PCT[ph]);
                end
                sent_in_phase += seg;
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && dates_due.size() == 0) begin
            $display("epoch_to_calendar_date verification clean");
        end else begin
            $display("epoch_to_calendar_date verification failed");
        end
        $finish;
    end

endmodule

### epoch_to_calendar_date.f
rtl/ectd_pkg.sv
rtl/ectd_ctrl.sv
rtl/ectd_dp.sv
rtl/epoch_to_calendar_date.sv
tb/sv/tb.sv
